// ----- src/sensor_table_index_confirm_assert.svh -----
// assertion macros for the sensor table index confirm block
`ifndef SENSOR_TABLE_INDEX_CONFIRM_ASSERT_SVH
`define SENSOR_TABLE_INDEX_CONFIRM_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define STIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/stic_pkg.sv -----
// shared constants, types and state codes for the sensor table index confirm block
`default_nettype none
package stic_pkg;
	localparam int LastEntry = 100;
	localparam int AdcBits = 10;
	localparam int Depth = LastEntry + 1;
	localparam int AddrW = $clog2(Depth);
	localparam int CntW = $clog2(LastEntry + 2);
	localparam int CandW = 8;
	localparam int IdxW = 7;
	localparam int CfgIdxW = 8;
	localparam int CfgDataW = 10;

	localparam logic [CfgIdxW-1:0] RegOpenThr = 8'd0;
	localparam logic [CfgIdxW-1:0] RegErrCode = 8'd1;

	localparam logic OpSample = 1'b0;
	localparam logic OpTableWrite = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WALK,
		ST_OUT
	} stic_state_t;

	typedef struct packed {
		logic done;
		logic [CandW-1:0] cand;
	} stic_res_t;
endpackage
`default_nettype wire

// ----- src/stic_table.sv -----
// calibration table memory, one write port and one registered read port
`default_nettype none
module stic_table (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [stic_pkg::AddrW-1:0] waddr,
	input  wire logic [stic_pkg::AdcBits-1:0] wdata,
	input  wire logic re,
	input  wire logic [stic_pkg::AddrW-1:0] raddr,
	output logic [stic_pkg::AdcBits-1:0] rdata
);
	logic [stic_pkg::AdcBits-1:0] mem [stic_pkg::Depth];
	logic [stic_pkg::AdcBits-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- src/stic_seq.sv -----
// search sequencer: walks the table one entry a cycle through one shared compare unit
`default_nettype none
`include "sensor_table_index_confirm_assert.svh"
module stic_seq (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [stic_pkg::AdcBits-1:0] reading,
	input  wire logic [stic_pkg::AdcBits-1:0] open_thr,
	input  wire logic [stic_pkg::CandW-1:0] err_code,
	input  wire logic out_free,
	output logic busy,
	output logic rd_en,
	output logic [stic_pkg::AddrW-1:0] rd_addr,
	input  wire logic [stic_pkg::AdcBits-1:0] rd_data,
	output stic_pkg::stic_res_t res
);
	localparam logic [stic_pkg::CntW-1:0] KEnd = stic_pkg::CntW'(stic_pkg::LastEntry + 1);
	localparam logic [stic_pkg::CntW-1:0] KOne = stic_pkg::CntW'(1);
	localparam logic [stic_pkg::CntW-1:0] KTwo = stic_pkg::CntW'(2);

	stic_pkg::stic_state_t state_q, state_d;
	logic [stic_pkg::CntW-1:0] k_q;
	logic found_q;
	logic [stic_pkg::AdcBits-1:0] x_q;
	logic [stic_pkg::AdcBits-1:0] lo_q;
	logic [stic_pkg::CandW-1:0] cand_q;
	logic is_open;
	logic hit;
	logic [stic_pkg::CandW-1:0] walk_cand;

	assign is_open = (reading >= open_thr);
	// shared compare unit: does x fall between the held entry and the one just read
	assign hit = (x_q >= lo_q) && (x_q <= rd_data);
	assign walk_cand = stic_pkg::CandW'(k_q - KTwo);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stic_pkg::ST_IDLE: begin
				if (start) begin
					state_d = is_open ? stic_pkg::ST_OUT : stic_pkg::ST_FETCH;
				end
			end
			stic_pkg::ST_FETCH: begin
				state_d = stic_pkg::ST_WALK;
			end
			stic_pkg::ST_WALK: begin
				if (k_q == KEnd) begin
					state_d = stic_pkg::ST_OUT;
				end
			end
			stic_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = stic_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stic_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy = 1'b1;
		rd_en = 1'b0;
		res.done = 1'b0;
		res.cand = cand_q;
		case (state_q)
			stic_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			stic_pkg::ST_FETCH: begin
				rd_en = 1'b1;
			end
			stic_pkg::ST_WALK: begin
				rd_en = (k_q != KEnd);
			end
			stic_pkg::ST_OUT: begin
				res.done = out_free;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign rd_addr = k_q[stic_pkg::AddrW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stic_pkg::ST_IDLE;
			k_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				stic_pkg::ST_IDLE: begin
					k_q <= '0;
					if (start) begin
						found_q <= 1'b0;
					end
				end
				stic_pkg::ST_FETCH: begin
					k_q <= KOne;
				end
				stic_pkg::ST_WALK: begin
					if (k_q != KEnd) begin
						k_q <= k_q + KOne;
					end
					if ((k_q != KOne) && hit) begin
						found_q <= 1'b1;
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			stic_pkg::ST_IDLE: begin
				if (start) begin
					x_q <= reading;
					cand_q <= is_open ? err_code : '0;
				end
			end
			stic_pkg::ST_WALK: begin
				lo_q <= rd_data;
				if (k_q == KEnd && x_q > rd_data) begin
					// above the last breakpoint overrides any match
					cand_q <= stic_pkg::CandW'(stic_pkg::LastEntry);
				end else if ((k_q != KOne) && hit && !found_q) begin
					cand_q <= walk_cand;
				end
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	`STIC_ASSERT_NOW(a_cnt_range, state_q == stic_pkg::ST_WALK, k_q <= KEnd, "walk counter overran")
	`STIC_ASSERT_NEXT(a_start_path, start && !busy, (state_q == stic_pkg::ST_FETCH) || (state_q == stic_pkg::ST_OUT), "sample did not start a search")
	`STIC_ASSERT_NOW(a_found_clr, $fell(found_q), $past(start), "match flag cleared without a new sample")
	`STIC_ASSERT_NOW(a_no_read_idle, state_q == stic_pkg::ST_IDLE, !rd_en && !res.done, "table read or result while idle")
endmodule
`default_nettype wire

// ----- src/sensor_table_index_confirm.sv -----
// top level: stream ports, config registers, table, search sequencer, pairing and output register
// usage:
//   s_* channel takes items; tuser is the op (0 = sample, 1 = table write), tdata holds
//   reading, entry_index and entry_value. a table write is absorbed on acceptance and gives
//   no result. a sample gives exactly one result item on the m_* channel.
//   cfg_* channel writes open_threshold (index 0) and error_code (index 1); it is always
//   ready, other indexes are dropped. write it only while the block is idle.
// search:
//   a sample at or above open_threshold skips the walk and is loaded into the output register
//   once that register is free. any other sample walks the whole table with one compare per
//   cycle before its result is loaded. the walk length is set by the single table read port
//   feeding the shared compare unit. s_tready is low from acceptance until the result is
//   loaded, so no new item is taken while a sample is in flight; a table write leaves
//   s_tready high.
// stall: the result sits in an output register, so the next item can be taken while it
//   waits; a finished search holds until that register is free.
// reset: config returns to 1023 / 255, pairing and display state clear to zero. the table
//   itself is not cleared and must be loaded before samples are sent.
`default_nettype none
module sensor_table_index_confirm (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [31:0] s_tdata,  // reading[9:0], entry_index[16:10], entry_value[26:17]
	input  wire logic s_tuser,         // op
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [23:0] m_tdata,       // sample_index[7:0], display_value[15:8], display_updated[16]
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [stic_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [stic_pkg::CfgDataW-1:0] cfg_data
);
	// config registers
	logic [stic_pkg::AdcBits-1:0] open_thr_q;
	logic [stic_pkg::CandW-1:0] err_code_q;

	// pairing state
	logic phase_q;
	logic [stic_pkg::CandW-1:0] first_q;
	logic [stic_pkg::CandW-1:0] conf_q;

	// output register
	logic m_valid_q;
	logic [stic_pkg::CandW-1:0] out_idx_q;
	logic [stic_pkg::CandW-1:0] out_disp_q;
	logic out_upd_q;

	// input field split
	logic in_op;
	logic [stic_pkg::AdcBits-1:0] in_reading;
	logic [stic_pkg::IdxW-1:0] in_entry_idx;
	logic [stic_pkg::AdcBits-1:0] in_entry_val;

	logic accept;
	logic start;
	logic tbl_we;
	logic busy;
	logic out_free;
	logic rd_en;
	logic [stic_pkg::AddrW-1:0] rd_addr;
	logic [stic_pkg::AdcBits-1:0] rd_data;
	stic_pkg::stic_res_t res;
	logic pair_match;
	logic [stic_pkg::CandW-1:0] disp_next;

	assign in_op = s_tuser;
	assign in_reading = s_tdata[9:0];
	assign in_entry_idx = s_tdata[16:10];
	assign in_entry_val = s_tdata[26:17];

	assign s_tready = !busy;
	assign accept = s_tvalid && s_tready;
	assign start = accept && (in_op == stic_pkg::OpSample);
	// entries past the last one are dropped
	assign tbl_we = accept && (in_op == stic_pkg::OpTableWrite)
		&& (in_entry_idx <= stic_pkg::IdxW'(stic_pkg::LastEntry));

	assign out_free = !m_valid_q || m_tready;

	stic_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (in_entry_idx[stic_pkg::AddrW-1:0]),
		.wdata (in_entry_val),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	stic_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.reading  (in_reading),
		.open_thr (open_thr_q),
		.err_code (err_code_q),
		.out_free (out_free),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.res      (res)
	);

	// config port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_thr_q <= stic_pkg::AdcBits'(1023);
			err_code_q <= stic_pkg::CandW'(255);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				stic_pkg::RegOpenThr: open_thr_q <= cfg_data[stic_pkg::AdcBits-1:0];
				stic_pkg::RegErrCode: err_code_q <= cfg_data[stic_pkg::CandW-1:0];
				default: begin
					open_thr_q <= open_thr_q;
				end
			endcase
		end
	end

	// second sample of a pair loads the display only if both candidates agree
	assign pair_match = phase_q && (first_q == res.cand);
	assign disp_next = pair_match ? res.cand : conf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			first_q <= '0;
			conf_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (res.done) begin
				phase_q <= !phase_q;
				if (!phase_q) begin
					first_q <= res.cand;
				end
				conf_q <= disp_next;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			out_idx_q <= res.cand;
			out_disp_q <= disp_next;
			out_upd_q <= pair_match;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {7'd0, out_upd_q, out_disp_q, out_idx_q};
endmodule
`default_nettype wire
